// ----- sv/rwhp_pkg.sv -----
package rwhp_pkg;

    localparam int unsigned NUM_W     = 42;
    localparam int unsigned DEN_W     = 49;
    localparam int unsigned REM_W     = DEN_W + 1;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [31:0] TAG_RIFF      = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT       = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_BYTES = 32'd16;

    typedef enum logic [4:0] {
        PH_RIFF_ID,
        PH_RIFF_LEN,
        PH_WAVE_ID,
        PH_FMT_ID,
        PH_FMT_LEN,
        PH_SKIP_FMT,
        PH_F_TAG,
        PH_F_CH,
        PH_F_RATE,
        PH_F_BRATE,
        PH_F_ALIGN,
        PH_F_BITS,
        PH_DATA_ID,
        PH_DATA_LEN,
        PH_SKIP_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_DIV
    } t_seq;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [15:0]       format_code;
        logic [15:0]       channel_count;
        logic [31:0]       sample_rate;
        logic [31:0]       byte_rate;
        logic [15:0]       frame_align;
        logic [4:0]        sample_bits;
        logic [31:0]       payload_offset;
        logic [31:0]       payload_length;
        logic [NUM_W-1:0]  duration_ms;
    } t_res_item;

    function automatic logic tag_rejected(input logic [15:0] tag);
        logic rej;
        case (tag) inside
            16'h0000, 16'h0002, 16'h0006, 16'h0007, 16'h0010,
            16'h0015, 16'h0016, 16'h0101, 16'h0102, 16'h0103: rej = 1'b1;
            default: rej = 1'b0;
        endcase
        return rej;
    endfunction

endpackage

// ----- sv/rwhp_if.sv -----
interface rwhp_in_if;
    logic                valid;
    logic                ready;
    rwhp_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rwhp_res_if;
    logic                valid;
    logic                ready;
    rwhp_pkg::t_res_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/riff_wave_header_parser_unit.sv -----
// channel  dir  payload                                  request
// i_byte   in   data_byte, first_byte, final_byte        one file byte
// o_res    out  status, format fields, offset, length,   one header result
//               duration_ms
//
// One byte per cycle while parsing. An accepted header then takes a multiply
// step and a restoring division (one quotient bit per step) before the
// result appears; i_byte.ready is low meanwhile. Error results appear the
// cycle after the byte. Synchronous reset returns the parser to the RIFF tag.
// i_byte.ready also drops while a result waits and o_res.ready is low.
module riff_wave_header_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rwhp_in_if.sink       i_byte,
    rwhp_res_if.source    o_res
);

    rwhp_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [1:0]       r_idx, n_idx, cur_idx;
    logic [23:0]      r_field, n_field, cur_field;
    logic [31:0]      r_pos, n_pos, cur_pos;
    logic [31:0]      r_chunk_id, n_chunk_id;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_skip, n_skip;
    logic [15:0]      r_format, n_format;
    logic [15:0]      r_channels, n_channels;
    logic [31:0]      r_rate, n_rate;
    logic [31:0]      r_brate, n_brate;
    logic [15:0]      r_align, n_align;
    logic [4:0]       r_bits, n_bits;

    rwhp_pkg::t_seq   r_seq, n_seq;
    logic [rwhp_pkg::CNT_W-1:0] r_cnt;
    logic [rwhp_pkg::NUM_W-1:0] r_quo, n_quo;
    logic [rwhp_pkg::DEN_W-1:0] r_den, r_rem, n_rem;

    rwhp_pkg::t_res_item r_out;
    logic                r_out_valid;

    logic        acc, in_rdy, mul_en, div_en, div_last;
    logic        res_ok, res_err, two_byte, fld_done;
    logic [31:0] fld_val, skip_len;
    logic [47:0] prod;
    logic [rwhp_pkg::DEN_W-1:0] den_val;
    logic [rwhp_pkg::NUM_W-1:0] num_val;
    logic [rwhp_pkg::REM_W-1:0] shifted, sub;
    logic        ge;
    rwhp_pkg::t_res_item err_item, ok_item;

    assign acc = i_byte.valid && in_rdy;
    assign i_byte.ready = in_rdy;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    assign cur_phase = i_byte.payload.first_byte ? rwhp_pkg::PH_RIFF_ID : r_phase;
    assign cur_idx   = i_byte.payload.first_byte ? 2'd0  : r_idx;
    assign cur_field = i_byte.payload.first_byte ? 24'd0 : r_field;
    assign cur_pos   = i_byte.payload.first_byte ? 32'd0 : r_pos;

    assign two_byte = cur_phase inside {rwhp_pkg::PH_F_TAG, rwhp_pkg::PH_F_CH,
                                        rwhp_pkg::PH_F_ALIGN, rwhp_pkg::PH_F_BITS};
    assign fld_val  = {8'd0, cur_field}
                    | ({24'd0, i_byte.payload.data_byte} << {cur_idx, 3'b000});
    assign fld_done = two_byte ? (cur_idx == 2'd1) : (cur_idx == 2'd3);
    assign skip_len = r_len - rwhp_pkg::FMT_MIN_BYTES;

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_field    = r_field;
        n_pos      = r_pos;
        n_chunk_id = r_chunk_id;
        n_len      = r_len;
        n_skip     = r_skip;
        n_format   = r_format;
        n_channels = r_channels;
        n_rate     = r_rate;
        n_brate    = r_brate;
        n_align    = r_align;
        n_bits     = r_bits;
        res_ok     = 1'b0;
        res_err    = 1'b0;
        if (acc) begin
            n_phase = cur_phase;
            n_idx   = cur_idx;
            n_field = cur_field;
            n_pos   = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
            if (cur_phase == rwhp_pkg::PH_SKIP_FMT || cur_phase == rwhp_pkg::PH_SKIP_DATA) begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) begin
                    n_phase = (cur_phase == rwhp_pkg::PH_SKIP_FMT) ?
                              rwhp_pkg::PH_FMT_ID : rwhp_pkg::PH_DATA_ID;
                end
            end else if (cur_phase != rwhp_pkg::PH_DONE) begin
                if (!fld_done) begin
                    n_field = fld_val[23:0];
                    n_idx   = cur_idx + 2'd1;
                end else begin
                    n_field = '0;
                    n_idx   = '0;
                    case (cur_phase)
                        rwhp_pkg::PH_RIFF_ID: begin
                            if (fld_val != rwhp_pkg::TAG_RIFF) res_err = 1'b1;
                            else n_phase = rwhp_pkg::PH_RIFF_LEN;
                        end
                        rwhp_pkg::PH_RIFF_LEN: n_phase = rwhp_pkg::PH_WAVE_ID;
                        rwhp_pkg::PH_WAVE_ID: begin
                            if (fld_val != rwhp_pkg::TAG_WAVE) res_err = 1'b1;
                            else n_phase = rwhp_pkg::PH_FMT_ID;
                        end
                        rwhp_pkg::PH_FMT_ID: begin
                            n_chunk_id = fld_val;
                            n_phase    = rwhp_pkg::PH_FMT_LEN;
                        end
                        rwhp_pkg::PH_FMT_LEN: begin
                            n_len = fld_val;
                            if (r_chunk_id == rwhp_pkg::TAG_FMT) begin
                                if (fld_val < rwhp_pkg::FMT_MIN_BYTES) res_err = 1'b1;
                                else n_phase = rwhp_pkg::PH_F_TAG;
                            end else if (fld_val == 32'd0) begin
                                n_phase = rwhp_pkg::PH_FMT_ID;
                            end else begin
                                n_skip  = fld_val;
                                n_phase = rwhp_pkg::PH_SKIP_FMT;
                            end
                        end
                        rwhp_pkg::PH_F_TAG: begin
                            n_format = fld_val[15:0];
                            if (rwhp_pkg::tag_rejected(fld_val[15:0])) res_err = 1'b1;
                            else n_phase = rwhp_pkg::PH_F_CH;
                        end
                        rwhp_pkg::PH_F_CH: begin
                            n_channels = fld_val[15:0];
                            n_phase    = rwhp_pkg::PH_F_RATE;
                        end
                        rwhp_pkg::PH_F_RATE: begin
                            n_rate  = fld_val;
                            n_phase = rwhp_pkg::PH_F_BRATE;
                        end
                        rwhp_pkg::PH_F_BRATE: begin
                            n_brate = fld_val;
                            n_phase = rwhp_pkg::PH_F_ALIGN;
                        end
                        rwhp_pkg::PH_F_ALIGN: begin
                            n_align = fld_val[15:0];
                            n_phase = rwhp_pkg::PH_F_BITS;
                        end
                        rwhp_pkg::PH_F_BITS: begin
                            n_bits = fld_val[4:0];
                            if (fld_val[15:0] != 16'd8 && fld_val[15:0] != 16'd16) begin
                                res_err = 1'b1;
                            end else if (skip_len == 32'd0) begin
                                n_phase = rwhp_pkg::PH_DATA_ID;
                            end else begin
                                n_skip  = skip_len;
                                n_phase = rwhp_pkg::PH_SKIP_DATA;
                            end
                        end
                        rwhp_pkg::PH_DATA_ID: begin
                            n_chunk_id = fld_val;
                            n_phase    = rwhp_pkg::PH_DATA_LEN;
                        end
                        rwhp_pkg::PH_DATA_LEN: begin
                            n_len = fld_val;
                            if (r_chunk_id == rwhp_pkg::TAG_DATA) begin
                                res_ok = 1'b1;
                            end else if (fld_val == 32'd0) begin
                                n_phase = rwhp_pkg::PH_DATA_ID;
                            end else begin
                                n_skip  = fld_val;
                                n_phase = rwhp_pkg::PH_SKIP_DATA;
                            end
                        end
                        default: n_phase = rwhp_pkg::PH_DONE;
                    endcase
                end
            end
            if (cur_phase != rwhp_pkg::PH_DONE && !res_ok && !res_err
                    && i_byte.payload.final_byte) begin
                res_err = 1'b1;
            end
            if (res_ok || res_err) n_phase = rwhp_pkg::PH_DONE;
        end
    end

    // sequencer: next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            rwhp_pkg::SEQ_IDLE: if (res_ok) n_seq = rwhp_pkg::SEQ_MUL;
            rwhp_pkg::SEQ_MUL:  n_seq = rwhp_pkg::SEQ_DIV;
            rwhp_pkg::SEQ_DIV:  if (div_last) n_seq = rwhp_pkg::SEQ_IDLE;
            default:            n_seq = rwhp_pkg::SEQ_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        in_rdy   = 1'b0;
        mul_en   = 1'b0;
        div_en   = 1'b0;
        div_last = 1'b0;
        case (r_seq)
            rwhp_pkg::SEQ_IDLE: in_rdy = !r_out_valid || o_res.ready;
            rwhp_pkg::SEQ_MUL:  mul_en = 1'b1;
            rwhp_pkg::SEQ_DIV: begin
                div_en   = 1'b1;
                div_last = (r_cnt == rwhp_pkg::CNT_W'(rwhp_pkg::DIV_STEPS - 1));
            end
            default: ;
        endcase
    end

    // duration: len*1000 / (channels*rate*bytes_per_sample)
    assign prod    = 48'(r_channels) * 48'(r_rate);
    assign den_val = r_bits[4] ? {prod, 1'b0} : {1'b0, prod};
    assign num_val = {r_len, 10'd0} - {6'd0, r_len, 4'd0} - {7'd0, r_len, 3'd0};

    assign shifted = {r_rem, r_quo[rwhp_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign sub     = shifted - {1'b0, r_den};
    assign n_rem   = ge ? sub[rwhp_pkg::DEN_W-1:0] : shifted[rwhp_pkg::DEN_W-1:0];
    assign n_quo   = {r_quo[rwhp_pkg::NUM_W-2:0], ge};

    always_comb begin
        err_item        = '0;
        err_item.status = 1'b1;
        ok_item                = '0;
        ok_item.format_code    = r_format;
        ok_item.channel_count  = r_channels;
        ok_item.sample_rate    = r_rate;
        ok_item.byte_rate      = r_brate;
        ok_item.frame_align    = r_align;
        ok_item.sample_bits    = r_bits;
        ok_item.payload_offset = r_pos;
        ok_item.payload_length = r_len;
        ok_item.duration_ms    = (r_den == '0) ? '0 : n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rwhp_pkg::PH_RIFF_ID;
            r_idx       <= '0;
            r_field     <= '0;
            r_pos       <= '0;
            r_seq       <= rwhp_pkg::SEQ_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_field <= n_field;
            r_pos   <= n_pos;
            r_seq   <= n_seq;
            if (mul_en) r_cnt <= '0;
            else if (div_en) r_cnt <= r_cnt + rwhp_pkg::CNT_W'(1);
            if (res_err || div_last) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk_id <= n_chunk_id;
        r_len      <= n_len;
        r_skip     <= n_skip;
        r_format   <= n_format;
        r_channels <= n_channels;
        r_rate     <= n_rate;
        r_brate    <= n_brate;
        r_align    <= n_align;
        r_bits     <= n_bits;
        if (mul_en) begin
            r_quo <= num_val;
            r_den <= den_val;
            r_rem <= '0;
        end else if (div_en) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (res_err) r_out <= err_item;
        else if (div_last) r_out <= ok_item;
    end

endmodule

// ----- dv/riff_wave_header_parser_unit_tb.sv -----
`timescale 1ns / 1ps

typedef enum {
    HDR_NONE,
    HDR_OK,
    HDR_BAD
} t_hdr_verdict;

class wav_header_scoreboard;
    rwhp_pkg::t_phase    phase;
    logic [1:0]          lane;
    logic [31:0]         gather;
    logic [31:0]         chunk_tag;
    logic [31:0]         chunk_len;
    logic [31:0]         skip_left;
    logic [31:0]         position;
    logic [15:0]         fmt_tag;
    logic [15:0]         chans;
    logic [31:0]         rate;
    logic [31:0]         brate;
    logic [15:0]         align;
    logic [15:0]         bits;
    rwhp_pkg::t_res_item header_q[$];
    int unsigned         mismatches;

    function new();
        clear_state();
        mismatches = 0;
    endfunction

    function void clear_state();
        phase     = rwhp_pkg::PH_RIFF_ID;
        lane      = '0;
        gather    = '0;
        chunk_tag = '0;
        chunk_len = '0;
        skip_left = '0;
        position  = '0;
        fmt_tag   = '0;
        chans     = '0;
        rate      = '0;
        brate     = '0;
        align     = '0;
        bits      = '0;
    endfunction

    function void enter_skip(logic [31:0] len, rwhp_pkg::t_phase skip_ph,
                             rwhp_pkg::t_phase next_ph);
        if (len == 0) begin
            phase = next_ph;
        end else begin
            skip_left = len;
            phase     = skip_ph;
        end
    endfunction

    function bit is_compressed(logic [15:0] tag);
        return tag inside {16'h0000, 16'h0002, 16'h0006, 16'h0007, 16'h0010,
                           16'h0015, 16'h0016, 16'h0101, 16'h0102, 16'h0103};
    endfunction

    function t_hdr_verdict parse_byte(logic [7:0] b);
        int unsigned width;
        logic [31:0] v;
        if (phase == rwhp_pkg::PH_SKIP_FMT || phase == rwhp_pkg::PH_SKIP_DATA) begin
            skip_left = skip_left - 1;
            if (skip_left == 0) begin
                if (phase == rwhp_pkg::PH_SKIP_FMT) phase = rwhp_pkg::PH_FMT_ID;
                else phase = rwhp_pkg::PH_DATA_ID;
            end
            return HDR_NONE;
        end
        width  = (phase inside {rwhp_pkg::PH_F_TAG, rwhp_pkg::PH_F_CH,
                                rwhp_pkg::PH_F_ALIGN, rwhp_pkg::PH_F_BITS}) ? 2 : 4;
        gather = gather | (32'(b) << (8 * lane));
        lane   = lane + 2'd1;
        if (lane != 0 && int'(lane) < width) return HDR_NONE;
        v      = gather;
        gather = '0;
        lane   = '0;
        case (phase)
            rwhp_pkg::PH_RIFF_ID: begin
                if (v != rwhp_pkg::TAG_RIFF) return HDR_BAD;
                phase = rwhp_pkg::PH_RIFF_LEN;
            end
            rwhp_pkg::PH_RIFF_LEN: phase = rwhp_pkg::PH_WAVE_ID;
            rwhp_pkg::PH_WAVE_ID: begin
                if (v != rwhp_pkg::TAG_WAVE) return HDR_BAD;
                phase = rwhp_pkg::PH_FMT_ID;
            end
            rwhp_pkg::PH_FMT_ID: begin
                chunk_tag = v;
                phase     = rwhp_pkg::PH_FMT_LEN;
            end
            rwhp_pkg::PH_FMT_LEN: begin
                chunk_len = v;
                if (chunk_tag == rwhp_pkg::TAG_FMT) begin
                    if (v < rwhp_pkg::FMT_MIN_BYTES) return HDR_BAD;
                    phase = rwhp_pkg::PH_F_TAG;
                end else begin
                    enter_skip(v, rwhp_pkg::PH_SKIP_FMT, rwhp_pkg::PH_FMT_ID);
                end
            end
            rwhp_pkg::PH_F_TAG: begin
                fmt_tag = v[15:0];
                if (is_compressed(fmt_tag)) return HDR_BAD;
                phase = rwhp_pkg::PH_F_CH;
            end
            rwhp_pkg::PH_F_CH: begin
                chans = v[15:0];
                phase = rwhp_pkg::PH_F_RATE;
            end
            rwhp_pkg::PH_F_RATE: begin
                rate  = v;
                phase = rwhp_pkg::PH_F_BRATE;
            end
            rwhp_pkg::PH_F_BRATE: begin
                brate = v;
                phase = rwhp_pkg::PH_F_ALIGN;
            end
            rwhp_pkg::PH_F_ALIGN: begin
                align = v[15:0];
                phase = rwhp_pkg::PH_F_BITS;
            end
            rwhp_pkg::PH_F_BITS: begin
                bits = v[15:0];
                if (bits != 16'd8 && bits != 16'd16) return HDR_BAD;
                enter_skip(chunk_len - rwhp_pkg::FMT_MIN_BYTES,
                           rwhp_pkg::PH_SKIP_DATA, rwhp_pkg::PH_DATA_ID);
            end
            rwhp_pkg::PH_DATA_ID: begin
                chunk_tag = v;
                phase     = rwhp_pkg::PH_DATA_LEN;
            end
            rwhp_pkg::PH_DATA_LEN: begin
                chunk_len = v;
                if (chunk_tag == rwhp_pkg::TAG_DATA) return HDR_OK;
                enter_skip(v, rwhp_pkg::PH_SKIP_DATA, rwhp_pkg::PH_DATA_ID);
            end
            default: ;
        endcase
        return HDR_NONE;
    endfunction

    function void note_byte(rwhp_pkg::t_in_item req);
        t_hdr_verdict        verdict;
        rwhp_pkg::t_res_item hdr;
        logic [63:0]         divisor;
        logic [63:0]         scaled;
        if (req.first_byte) clear_state();
        if (position != 32'hFFFF_FFFF) position = position + 1;
        if (phase == rwhp_pkg::PH_DONE) return;
        verdict = parse_byte(req.data_byte);
        if (verdict == HDR_NONE && req.final_byte) verdict = HDR_BAD;
        if (verdict == HDR_NONE) return;
        phase = rwhp_pkg::PH_DONE;
        hdr   = '0;
        if (verdict == HDR_BAD) begin
            hdr.status = 1'b1;
        end else begin
            divisor = 64'(chans) * 64'(rate) * 64'(bits / 16'd8);
            scaled  = 64'(chunk_len) * 64'd1000;
            hdr.format_code    = fmt_tag;
            hdr.channel_count  = chans;
            hdr.sample_rate    = rate;
            hdr.byte_rate      = brate;
            hdr.frame_align    = align;
            hdr.sample_bits    = bits[4:0];
            hdr.payload_offset = position;
            hdr.payload_length = chunk_len;
            hdr.duration_ms    = (divisor == 0) ? '0 : rwhp_pkg::NUM_W'(scaled / divisor);
        end
        header_q.push_back(hdr);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(rwhp_pkg::t_res_item got);
        rwhp_pkg::t_res_item want;
        if (header_q.size() == 0) begin
            report_mismatch("header result with none pending");
            return;
        end
        want = header_q.pop_front();
        compare_field("status", 64'(got.status), 64'(want.status));
        compare_field("format_code", 64'(got.format_code), 64'(want.format_code));
        compare_field("channel_count", 64'(got.channel_count), 64'(want.channel_count));
        compare_field("sample_rate", 64'(got.sample_rate), 64'(want.sample_rate));
        compare_field("byte_rate", 64'(got.byte_rate), 64'(want.byte_rate));
        compare_field("frame_align", 64'(got.frame_align), 64'(want.frame_align));
        compare_field("sample_bits", 64'(got.sample_bits), 64'(want.sample_bits));
        compare_field("payload_offset", 64'(got.payload_offset), 64'(want.payload_offset));
        compare_field("payload_length", 64'(got.payload_length), 64'(want.payload_length));
        compare_field("duration_ms", 64'(got.duration_ms), 64'(want.duration_ms));
    endtask
endclass

module riff_wave_header_parser_unit_tb;

    localparam int unsigned RANDOM_BYTES = 1550;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam logic [15:0] COMPRESSED_TAGS [10] = '{
        16'h0000, 16'h0002, 16'h0006, 16'h0007, 16'h0010,
        16'h0015, 16'h0016, 16'h0101, 16'h0102, 16'h0103
    };
    localparam logic [31:0] COMMON_RATES [5] = '{
        32'd8000, 32'd11025, 32'd22050, 32'd44100, 32'd48000
    };

    logic i_clk;
    logic i_rst_n;

    rwhp_in_if  in_ch ();
    rwhp_res_if res_ch ();

    riff_wave_header_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (in_ch),
        .o_res   (res_ch)
    );

    wav_header_scoreboard sb = new();
    rwhp_pkg::t_in_item file_q[$];
    int unsigned        bytes_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void put_le(logic [31:0] v, int unsigned n);
        rwhp_pkg::t_in_item req;
        for (int i = 0; i < n; i++) begin
            req           = '0;
            req.data_byte = v[8*i +: 8];
            file_q.push_back(req);
        end
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_le(32'(s[i]), 1);
    endfunction

    function automatic logic [31:0] maybe_corrupt(logic [31:0] v);
        int unsigned k;
        k = $urandom_range(0, 31);
        if ($urandom_range(0, 39) == 0) v[k] = ~v[k];
        return v;
    endfunction

    function automatic void put_junk_chunk();
        int unsigned sel;
        int unsigned body;
        logic [31:0] len;
        sel = $urandom_range(0, 99);
        if (sel < 15) len = '0;
        else if (sel < 97) len = $urandom_range(1, 13);
        else len = $urandom;
        put_le($urandom, 4);
        put_le(len, 4);
        body = (len > 13) ? $urandom_range(0, 8) : len;
        for (int i = 0; i < body; i++) put_le($urandom, 1);
    endfunction

    function automatic void build_random_file();
        int unsigned sel;
        int unsigned extra;
        int unsigned cut;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        file_q.delete();
        put_le(maybe_corrupt(rwhp_pkg::TAG_RIFF), 4);
        put_le($urandom, 4);
        put_le(maybe_corrupt(rwhp_pkg::TAG_WAVE), 4);
        sel = $urandom_range(0, 9);
        for (int i = 0; i < (sel < 6 ? 0 : sel < 9 ? 1 : 2); i++) put_junk_chunk();
        put_le(maybe_corrupt(rwhp_pkg::TAG_FMT), 4);
        extra   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        fmt_len = ($urandom_range(0, 19) == 0) ? 32'($urandom_range(0, 15)) : 32'(16 + extra);
        put_le(fmt_len, 4);
        sel = $urandom_range(0, 9);
        if (sel < 6) put_le(32'h0000_0001, 2);
        else if (sel == 6) put_le(32'h0000_0003, 2);
        else if (sel == 7) put_le(32'h0000_FFFE, 2);
        else if (sel == 8) put_le(32'(COMPRESSED_TAGS[$urandom_range(0, 9)]), 2);
        else put_le($urandom, 2);
        sel = $urandom_range(0, 9);
        if (sel < 7) put_le($urandom_range(1, 2), 2);
        else if (sel == 7) put_le(0, 2);
        else put_le($urandom, 2);
        sel = $urandom_range(0, 19);
        if (sel < 15) put_le(COMMON_RATES[$urandom_range(0, 4)], 4);
        else if (sel < 17) put_le(0, 4);
        else put_le($urandom, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        sel = $urandom_range(0, 19);
        if (sel < 9) put_le(32'd8, 2);
        else if (sel < 18) put_le(32'd16, 2);
        else put_le($urandom, 2);
        for (int i = 0; i < extra; i++) put_le($urandom, 1);
        sel = $urandom_range(0, 9);
        for (int i = 0; i < (sel < 6 ? 0 : sel < 9 ? 1 : 2); i++) put_junk_chunk();
        put_le(maybe_corrupt(rwhp_pkg::TAG_DATA), 4);
        sel = $urandom_range(0, 9);
        if (sel < 5) data_len = $urandom;
        else if (sel < 8) data_len = $urandom_range(0, 5000);
        else if (sel == 8) data_len = '0;
        else data_len = 32'hFFFF_FFFF;
        put_le(data_len, 4);
        for (int i = 0; i < $urandom_range(0, 4); i++) put_le($urandom, 1);
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            cut = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > cut + 1) void'(file_q.pop_back());
        end
        if (sel >= 5) file_q[file_q.size() - 1].final_byte = 1'b1;
        file_q[0].first_byte = 1'b1;
    endfunction

    task automatic send_byte(rwhp_pkg::t_in_item req, bit calm);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= req;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(req);
        bytes_sent++;
    endtask

    task automatic play_file();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (file_q[i]) send_byte(file_q[i], calm);
    endtask

    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          calm;
        taken        = 0;
        calm         = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 6 == 0) calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, 19);
            if (taken == 6) stall = LONG_HOLD;
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            sb.check_result(res_ch.payload);
            taken++;
        end
    end

    initial begin : byte_source
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone byte that is both first and last
        file_q.delete();
        put_le(32'hFF, 1);
        file_q[0].first_byte = 1'b1;
        file_q[0].final_byte = 1'b1;
        play_file();

        // bad RIFF tag, then a byte that must be ignored
        file_q.delete();
        put_text("RIFX");
        put_le(32'h00, 1);
        file_q[0].first_byte = 1'b1;
        play_file();

        // restart inside an unfinished file, then end inside the RIFF length
        file_q.delete();
        put_text("RIF");
        file_q[0].first_byte = 1'b1;
        play_file();
        file_q.delete();
        put_text("RIFF");
        put_le(32'h0, 2);
        file_q[0].first_byte = 1'b1;
        file_q[5].final_byte = 1'b1;
        play_file();

        // bad WAVE tag on the final byte
        file_q.delete();
        put_text("RIFF");
        put_le(32'hFFFF_FFFF, 4);
        put_text("WAVX");
        file_q[0].first_byte  = 1'b1;
        file_q[11].final_byte = 1'b1;
        play_file();

        while (bytes_sent < RANDOM_BYTES) begin
            build_random_file();
            play_file();
        end
        in_ch.valid <= 1'b0;

        while (sb.header_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
